// ----- hdl/cobs_pkg.sv -----
// cobs_pkg: shared types and constants for the COBS block encoder.
// Holds the engine state type, command codes, register indexes and field widths.
// No dependencies.
package cobs_pkg;

    // Engine sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,   // taking words, buffering data bytes
        ST_CODE,   // sending the block code byte
        ST_DATA,   // draining stored bytes from the block store
        ST_TAIL    // sending a trailing delimiter or a lone code byte
    } t_state;

    // Input command codes (tuser bit 0)
    localparam logic CMD_DATA   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH = 2'd1;

    // Field widths and fixed values
    localparam int BYTE_W      = 8;
    localparam int DEPTH_W     = 6;
    localparam int MIN_DEPTH   = 2;
    localparam int DEPTH_RESET = 63;

endpackage

// ----- hdl/cobs_store.sv -----
// cobs_store: block store RAM, one write port and one read port.
// Read data is registered. Uses cobs_pkg for byte width.
module cobs_store
    import cobs_pkg::*;
#(
    parameter int DEPTH = 63,
    parameter int AW    = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [BYTE_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/cobs_block_encoder.sv -----
// cobs_block_encoder: top level of the COBS block encoder.
// Depends on cobs_pkg and cobs_store (block store RAM).
//
// Usage:
//   Input stream (i_s_*): one word per item. tdata carries the data byte,
//   tuser bit 0 the command (data or finish), tuser bit 1 the flag that
//   appends the delimiter after a finish flush.
//   Output stream (o_m_*): one encoded byte per word; tuser marks a block
//   code byte, tlast marks the final word caused by one input word.
//   Config port (i_cfg_*): register 0 is the delimiter byte, register 1 the
//   block depth (low 6 bits). Always ready; write only while the block idles.
// Timing:
//   A data byte that is only buffered is taken in ST_IDLE; words may follow
//   back to back. A word that flushes a block is accepted, then the block
//   sends its output words: the code byte, the stored bytes read one per
//   cycle from the single read port of the block store while the output is
//   not stalled, and an optional delimiter or lone code byte (at most 64
//   output words), all sent through the output register.
// Reset: delimiter 0, depth 63, empty block; store contents stay undefined.
// Stall: the output register holds its word while i_m_tready is low and the
//   drain pauses; the next input word is taken while the last one waits.
module cobs_block_encoder
    import cobs_pkg::*;
#(
    parameter int MAX_BLOCK = 63
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [BYTE_W-1:0]    i_s_tdata,   // [7:0] data_byte
    input  logic [1:0]           i_s_tuser,   // [0] cmd, [1] append_delimiter
    // output stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [BYTE_W-1:0]    o_m_tdata,   // [7:0] out_byte
    output logic                 o_m_tuser,   // [0] is_code
    output logic                 o_m_tlast,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

    localparam int FW = $clog2(MAX_BLOCK + 1);
    localparam int AW = $clog2(MAX_BLOCK);
    localparam logic [DEPTH_W-1:0] MAX_D = DEPTH_W'(MAX_BLOCK);
    localparam logic [DEPTH_W-1:0] MIN_D = DEPTH_W'(MIN_DEPTH);
    localparam logic [FW-1:0]      ONE_F = FW'(1);
    localparam logic [FW-1:0]      TWO_F = FW'(2);

    // config registers
    logic [BYTE_W-1:0]  r_delim;
    logic [DEPTH_W-1:0] r_depth;

    // engine state
    t_state             r_state, n_state;
    logic [FW-1:0]      r_fill, n_fill;
    logic [FW-1:0]      r_ptr, n_ptr;
    logic [BYTE_W-1:0]  r_byte, n_byte;
    logic               r_finish, n_finish;
    logic               r_full, n_full;
    logic               r_tail, n_tail;

    // output register
    logic               r_ovalid, n_ovalid;
    logic [BYTE_W-1:0]  r_odata;
    logic               r_ocode;
    logic               r_olast;

    // engine to output register / RAM
    logic               w_load;
    logic [BYTE_W-1:0]  w_ld_data;
    logic               w_ld_code;
    logic               w_ld_last;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [BYTE_W-1:0]  w_wdata;
    logic [BYTE_W-1:0]  w_rdata;

    logic               w_accept;
    logic               w_ofree;
    logic [DEPTH_W-1:0] w_depth_c;
    logic [FW-1:0]      w_eff;
    logic               w_full;
    logic               w_is_delim;
    logic [BYTE_W-1:0]  w_fill_b;
    logic [BYTE_W-1:0]  w_code;
    logic [BYTE_W-1:0]  w_lone_code;
    logic               w_ptr_end;
    logic               w_end;

    // Block store
    cobs_store #(
        .DEPTH (MAX_BLOCK),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (n_ptr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // Config writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= '0;
            r_depth <= DEPTH_W'(DEPTH_RESET);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DELIM: r_delim <= i_cfg_data;
                REG_DEPTH: r_depth <= i_cfg_data[DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective depth, clamped to the supported range
    assign w_depth_c = (r_depth < MIN_D) ? MIN_D :
                       (r_depth > MAX_D) ? MAX_D : r_depth;
    assign w_eff     = w_depth_c[FW-1:0];

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_ofree    = !r_ovalid || i_m_tready;

    assign w_full     = (r_fill >= w_eff);
    assign w_is_delim = (i_s_tdata == r_delim);

    // Code byte; a code that collides with a nonzero delimiter goes out as 0
    assign w_fill_b    = BYTE_W'(r_fill);
    assign w_code      = (w_fill_b == r_delim && r_delim != '0) ? '0 : w_fill_b;
    assign w_lone_code = (r_delim == BYTE_W'(1)) ? '0 : BYTE_W'(1);

    assign w_ptr_end = (r_ptr == r_fill - ONE_F);

    // Sequencer: next state, RAM writes, output loads
    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_ptr     = r_ptr;
        n_byte    = r_byte;
        n_finish  = r_finish;
        n_full    = r_full;
        n_tail    = r_tail;
        w_we      = 1'b0;
        w_waddr   = r_fill[AW-1:0];
        w_wdata   = i_s_tdata;
        w_load    = 1'b0;
        w_ld_data = w_code;
        w_ld_code = 1'b0;
        w_ld_last = 1'b0;
        w_end     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_ptr  = ONE_F;
                    n_byte = i_s_tdata;
                    if (i_s_tuser[0] == CMD_FINISH) begin
                        if (r_fill >= TWO_F) begin
                            n_state  = ST_CODE;
                            n_finish = 1'b1;
                            n_full   = 1'b0;
                            n_tail   = i_s_tuser[1];
                        end
                    end else if (!w_is_delim && !w_full) begin
                        w_we   = 1'b1;
                        n_fill = r_fill + ONE_F;
                    end else begin
                        n_state  = ST_CODE;
                        n_finish = 1'b0;
                        n_full   = w_full;
                        n_tail   = w_full && w_is_delim;
                    end
                end
            end
            ST_CODE: begin
                // read of entry 1 is in flight during this state
                if (w_ofree) begin
                    w_load    = 1'b1;
                    w_ld_data = w_code;
                    w_ld_code = 1'b1;
                    w_ld_last = (r_fill < TWO_F) && !r_tail;
                    if (r_fill >= TWO_F) begin
                        n_state = ST_DATA;
                    end else begin
                        w_end = 1'b1;
                    end
                end
            end
            ST_DATA: begin
                if (w_ofree) begin
                    w_load    = 1'b1;
                    w_ld_data = w_rdata;
                    w_ld_last = w_ptr_end && !r_tail;
                    n_ptr     = r_ptr + ONE_F;
                    w_end     = w_ptr_end;
                end
            end
            ST_TAIL: begin
                if (w_ofree) begin
                    w_load    = 1'b1;
                    w_ld_data = r_finish ? r_delim : w_lone_code;
                    w_ld_code = !r_finish;
                    w_ld_last = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
        endcase

        // End of a flush: empty block, then restart with the pending byte if a full block left one
        if (w_end) begin
            n_state = r_tail ? ST_TAIL : ST_IDLE;
            n_fill  = ONE_F;
            if (!r_finish && r_full && !r_tail) begin
                w_we    = 1'b1;
                w_waddr = AW'(1);
                w_wdata = r_byte;
                n_fill  = TWO_F;
            end
        end

        if (w_load) begin
            n_ovalid = 1'b1;
        end else if (i_m_tready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fill   <= ONE_F;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_ovalid <= n_ovalid;
        end
    end

    // Context and output payload
    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_byte   <= n_byte;
        r_finish <= n_finish;
        r_full   <= n_full;
        r_tail   <= n_tail;
        if (w_load) begin
            r_odata <= w_ld_data;
            r_ocode <= w_ld_code;
            r_olast <= w_ld_last;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ocode;
    assign o_m_tlast  = r_olast;

endmodule

// ----- hdl/cobs_enc_chk.sv -----
// cobs_enc_chk: port-level checks for cobs_block_encoder, bound to the top.
// Depends on cobs_pkg and the top level's port list.
module cobs_enc_chk
    import cobs_pkg::*;
#(
    parameter int MAX_BLOCK = 63
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_s_tready,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [BYTE_W-1:0]    o_m_tdata,
    input logic                 o_m_tuser,
    input logic                 o_m_tlast
);

    // Output empties on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output word valid after reset");

    // Stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled output word changed");

    // Code byte never exceeds the block capacity
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata <= BYTE_W'(MAX_BLOCK))
        else $error("code byte out of range");

    // A word that is not the last of its run means the flush is still busy
    a_busy_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> !o_s_tready)
        else $error("input taken in the middle of a flush");

endmodule

bind cobs_block_encoder cobs_enc_chk #(.MAX_BLOCK(MAX_BLOCK)) u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_s_tready  (o_s_tready),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tuser   (o_m_tuser),
    .o_m_tlast   (o_m_tlast)
);
